// ----- rtl/core/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  localparam int unsigned MagW = 64;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_SUB    = 3'd1,
    KIND_MUL    = 3'd2,
    KIND_DIV    = 3'd3,
    KIND_IDIV   = 3'd4,
    KIND_CMP    = 3'd5,
    KIND_REDUCE = 3'd6,
    KIND_NONE   = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ORDER_LESS    = 2'd0,
    ORDER_EQUAL   = 2'd1,
    ORDER_GREATER = 2'd2
  } order_e;

  // Operand pair fed to the shared divider.
  typedef enum logic [1:0] {
    DIV_GCD = 2'd0,  // gcd remainder
    DIV_NUM = 2'd1,  // numerator by gcd
    DIV_DEN = 2'd2,  // denominator by gcd
    DIV_QUO = 2'd3   // numerator by denominator
  } div_sel_e;

  // Operations the controller asks of the datapath.
  typedef struct packed {
    logic load;       // capture operands
    logic mul_x;      // form first product pair
    logic mul_y;      // form second product pair
    logic combine;    // build numerator / denominator
    logic gcd_init;   // seed Euclid registers
    logic div_start;  // start a long division
    div_sel_e div_sel;
    logic div_step;   // one restoring step
    logic gcd_take;   // a <= b, b <= remainder
    logic store_num;  // keep quotient as reduced numerator
    logic store_den;  // keep quotient as reduced denominator
    logic store_q;    // keep quotient for idiv
    logic finish;     // build result fields
  } rau_cmd_t;

  typedef struct packed {
    logic gcd_done;   // b is zero
    logic div_done;   // last step being taken
    logic g_big;      // gcd greater than one
    logic den_zero;   // reduced denominator is zero
  } rau_stat_t;

endpackage

// ----- rtl/core/rau_datapath.sv -----
// Datapath: operand products, sign handling, shared long divider and Euclid registers.
module rau_datapath
  import rau_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rau_cmd_t                 cmd_i,
  output rau_stat_t                stat_o,
  input  logic [2:0]               kind_i,
  input  logic signed [31:0]       a_num_i,
  input  logic signed [31:0]       a_den_i,
  input  logic signed [31:0]       b_num_i,
  input  logic signed [31:0]       b_den_i,
  output logic signed [63:0]       result_num_o,
  output logic [62:0]              result_den_o,
  output logic [1:0]               order_o,
  output logic                     status_o
);

  localparam int unsigned CntW = $clog2(MagW + 1);

  logic [2:0]         kind_q;
  logic signed [32:0] an_q, ad_q, bn_q, bd_q;
  logic signed [65:0] px_q, py_q, pz_q;
  logic               n_neg_q, d_neg_q;
  logic [MagW-1:0]    n_q, d_q;
  logic [MagW-1:0]    ga_q, gb_q;
  logic [MagW-1:0]    dvd_q, dvs_q, quo_q;
  logic [MagW:0]      rem_q;
  logic [CntW-1:0]    cnt_q;
  logic [MagW-1:0]    rn_q, rd_q;
  logic signed [63:0] res_num_q;
  logic [62:0]        res_den_q;
  logic [1:0]         order_q;
  logic               status_q;

  function automatic logic signed [32:0] sx(input logic [31:0] v);
    logic [OPERAND_WIDTH-1:0] low;
    low = v[OPERAND_WIDTH-1:0];
    return 33'(signed'(low));
  endfunction

  function automatic logic [MagW-1:0] mag66(input logic signed [65:0] v);
    logic [65:0] m;
    m = v[65] ? 66'(-v) : 66'(v);
    return m[MagW-1:0];
  endfunction

  // Select operand pairs per kind for the two multiplies.
  logic signed [32:0] mx1, mx2, my1, my2;
  always_comb begin
    mx1 = an_q; mx2 = bd_q; my1 = bn_q; my2 = ad_q;
    case (kind_e'(kind_q))
      KIND_MUL: begin
        mx1 = an_q; mx2 = bn_q; my1 = ad_q; my2 = bd_q;
      end
      KIND_DIV, KIND_IDIV: begin
        mx1 = an_q; mx2 = bd_q; my1 = ad_q; my2 = bn_q;
      end
      KIND_REDUCE: begin
        mx1 = an_q; mx2 = 33'sd1; my1 = ad_q; my2 = 33'sd1;
      end
      default: ;
    endcase
  end

  // Signed sum of two magnitude-limited products; fits 66 bits.
  logic signed [65:0] sum;
  always_comb begin
    sum = (kind_e'(kind_q) == KIND_SUB) ? px_q - py_q : px_q + py_q;
  end

  logic [MagW:0] trial;
  always_comb trial = {rem_q[MagW-1:0], dvd_q[MagW-1]} - {1'b0, dvs_q};

  logic [MagW-1:0] dv_a, dv_b;
  always_comb begin
    dv_a = ga_q; dv_b = gb_q;
    case (cmd_i.div_sel)
      DIV_NUM: begin dv_a = n_q;  dv_b = ga_q; end
      DIV_DEN: begin dv_a = d_q;  dv_b = ga_q; end
      DIV_QUO: begin dv_a = rn_q; dv_b = rd_q; end
      default: ;
    endcase
  end

  logic neg;
  always_comb neg = (n_neg_q != d_neg_q) && (n_q != '0);

  // Signed numerator bits; a positive magnitude of 2^63 saturates.
  logic signed [63:0] num_bits;
  always_comb begin
    if (neg) num_bits = 64'(-rn_q);
    else num_bits = rn_q[63] ? 64'h7FFF_FFFF_FFFF_FFFF : rn_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= '0;
      an_q <= '0; ad_q <= '0; bn_q <= '0; bd_q <= '0;
      px_q <= '0; py_q <= '0; pz_q <= '0;
      n_q <= '0; d_q <= '0; n_neg_q <= 1'b0; d_neg_q <= 1'b0;
      ga_q <= '0; gb_q <= '0;
      dvd_q <= '0; dvs_q <= '0; quo_q <= '0; rem_q <= '0;
      cnt_q <= '0;
      rn_q <= '0; rd_q <= '0;
      res_num_q <= '0; res_den_q <= '0; order_q <= '0; status_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        kind_q <= kind_i;
        an_q <= sx(a_num_i); ad_q <= sx(a_den_i);
        bn_q <= sx(b_num_i); bd_q <= sx(b_den_i);
      end
      if (cmd_i.mul_x) px_q <= 66'(mx1 * mx2);
      if (cmd_i.mul_y) begin
        py_q <= 66'(my1 * my2);
        // For add/sub the denominator is ad*bd; kept separately.
        pz_q <= 66'(ad_q * bd_q);
      end
      if (cmd_i.combine) begin
        if (kind_e'(kind_q) == KIND_ADD || kind_e'(kind_q) == KIND_SUB) begin
          n_q <= mag66(sum);   n_neg_q <= sum[65] && (sum != '0);
          d_q <= mag66(pz_q);  d_neg_q <= pz_q[65] && (pz_q != '0);
        end else begin
          n_q <= mag66(px_q);  n_neg_q <= px_q[65] && (px_q != '0);
          d_q <= mag66(py_q);  d_neg_q <= py_q[65] && (py_q != '0);
        end
      end
      if (cmd_i.gcd_init) begin
        ga_q <= n_q; gb_q <= d_q;
        rn_q <= n_q; rd_q <= d_q;
      end
      if (cmd_i.div_start) begin
        dvd_q <= dv_a; dvs_q <= dv_b; rem_q <= '0; quo_q <= '0;
        cnt_q <= CntW'(MagW);
      end else if (cmd_i.div_step) begin
        if (!trial[MagW]) begin
          rem_q <= trial;
          quo_q <= {quo_q[MagW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[MagW-1:0], dvd_q[MagW-1]};
          quo_q <= {quo_q[MagW-2:0], 1'b0};
        end
        dvd_q <= {dvd_q[MagW-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.gcd_take) begin
        ga_q <= gb_q; gb_q <= rem_q[MagW-1:0];
      end
      if (cmd_i.store_num) rn_q <= quo_q;
      if (cmd_i.store_den) rd_q <= quo_q;
      if (cmd_i.store_q) rn_q <= quo_q;
      if (cmd_i.finish) begin
        case (kind_e'(kind_q))
          KIND_CMP: begin
            res_num_q <= '0;
            res_den_q <= '0;
            status_q  <= 1'b0;
            order_q   <= (px_q < py_q) ? ORDER_LESS :
                         (px_q > py_q) ? ORDER_GREATER : ORDER_EQUAL;
          end
          KIND_NONE: begin
            res_num_q <= '0;
            res_den_q <= '0;
            status_q  <= 1'b0;
            order_q   <= ORDER_LESS;
          end
          KIND_IDIV: begin
            status_q  <= (rd_q == '0);
            res_den_q <= 63'd1;
            order_q   <= ORDER_LESS;
            res_num_q <= (rd_q == '0 || rn_q == '0) ? '0 : num_bits;
          end
          default: begin
            status_q  <= (rd_q == '0);
            res_den_q <= rd_q[62:0];
            order_q   <= ORDER_LESS;
            res_num_q <= num_bits;
          end
        endcase
      end
    end
  end

  assign stat_o.gcd_done = (gb_q == '0);
  assign stat_o.div_done = (cnt_q == CntW'(1));
  assign stat_o.g_big    = (ga_q > 64'd1);
  assign stat_o.den_zero = (rd_q == '0);

  assign result_num_o = res_num_q;
  assign result_den_o = res_den_q;
  assign order_o      = order_q;
  assign status_o     = status_q;

endmodule

// ----- rtl/core/rau_ctrl.sv -----
// Controller: sequences products, Euclid loop, reductions and output handshake.
module rau_ctrl
  import rau_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] kind_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rau_cmd_t   cmd_o,
  input  rau_stat_t  stat_i
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_MUL    = 11'b00000000010,
    S_COMB   = 11'b00000000100,
    S_GINIT  = 11'b00000001000,
    S_GTEST  = 11'b00000010000,
    S_GDIV   = 11'b00000100000,
    S_RNUM   = 11'b00001000000,
    S_RDEN   = 11'b00010000000,
    S_QDIV   = 11'b00100000000,
    S_FIN    = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] phase_q, phase_d;   // step within a divide run
  logic [2:0] kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= '0;
      kind_q  <= KIND_NONE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (state_q == S_IDLE && in_valid_i) kind_q <= kind_i;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_x = 1'b1;
        cmd_o.mul_y = 1'b1;
        state_d = (kind_e'(kind_q) == KIND_CMP || kind_e'(kind_q) == KIND_NONE)
                  ? S_FIN : S_COMB;
      end
      S_COMB: begin
        cmd_o.combine = 1'b1;
        state_d = S_GINIT;
      end
      S_GINIT: begin
        cmd_o.gcd_init = 1'b1;
        state_d = S_GTEST;
      end
      S_GTEST: begin
        // Launch the next modulo step, or move on to the reductions, the idiv quotient or the result.
        cmd_o.div_start = 1'b1;
        if (!stat_i.gcd_done) begin
          cmd_o.div_sel = DIV_GCD;
          state_d = S_GDIV;
        end else if (stat_i.g_big) begin
          cmd_o.div_sel = DIV_NUM;
          state_d = S_RNUM;
        end else begin
          cmd_o.div_sel = DIV_QUO;
          state_d = (kind_e'(kind_q) == KIND_IDIV && !stat_i.den_zero) ? S_QDIV : S_FIN;
        end
      end
      S_GDIV: begin
        if (phase_q == 2'd0) begin
          cmd_o.div_step = 1'b1;
          if (stat_i.div_done) phase_d = 2'd1;
        end else begin
          // Advance the Euclid pair: a takes b, b takes the remainder.
          cmd_o.gcd_take = 1'b1;
          phase_d = 2'd0;
          state_d = S_GTEST;
        end
      end
      S_RNUM: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = S_RDEN;
      end
      S_RDEN: begin
        if (phase_q == 2'd0) begin
          cmd_o.store_num = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_DEN;
          phase_d = 2'd1;
        end else if (phase_q == 2'd1) begin
          cmd_o.div_step = 1'b1;
          if (stat_i.div_done) phase_d = 2'd2;
        end else begin
          cmd_o.store_den = 1'b1;
          phase_d = 2'd0;
          state_d = (kind_e'(kind_q) == KIND_IDIV) ? S_QDIV : S_FIN;
        end
      end
      S_QDIV: begin
        if (phase_q == 2'd0) begin
          if (stat_i.den_zero) begin
            state_d = S_FIN;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DIV_QUO;
            phase_d = 2'd1;
          end
        end else if (phase_q == 2'd1) begin
          cmd_o.div_step = 1'b1;
          if (stat_i.div_done) phase_d = 2'd2;
        end else begin
          cmd_o.store_q = 1'b1;
          phase_d = 2'd0;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/rational_arithmetic_unit_top.sv -----
// Rational arithmetic unit: add, sub, mul, div, idiv, compare and reduce with GCD.
//
// Input channel: in_valid_i / in_stall_o with kind_i and the four operand fields.
// Output channel: out_valid_o / out_stall_i with result_num_o, result_den_o,
// order_o and status_o; one result beat per input beat.
// One item is in flight at a time; in_stall_o is high from acceptance until
// the result beat is taken.
// Compare and the unused kind skip the divider. Other kinds run the
// Euclid loop on a 64-bit restoring divider, one division per modulo step,
// then two divides to reduce when the gcd exceeds one, and one more for
// idiv with a nonzero denominator; all divides share the single divider.
// Reset clears the controller; the block comes up idle with no result pending.
// While the receiver stalls the result beat holds steady and no new item is
// accepted.
module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] a_num_i,
  input  logic signed [31:0] a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic signed [31:0] b_den_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] result_num_o,
  output logic [62:0]        result_den_o,
  output logic [1:0]         order_o,
  output logic               status_o
);

  rau_cmd_t  cmd;
  rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i,
    .out_valid_o, .out_stall_i, .cmd_o(cmd), .stat_i(stat)
  );

  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .kind_i,
    .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .result_num_o, .result_den_o, .order_o, .status_o
  );

endmodule

// ----- rtl/core/rau_checker.sv -----
// Port-level checks for the rational arithmetic unit, bound to the top level.
module rau_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [62:0] result_den_o,
  input logic [1:0]  order_o,
  input logic        status_o
);

  // Accepting an item starts work: the input stalls next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // No new item while a result waits.
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open with result pending");

  // A held result stays valid with its denominator unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_den_o)))
    else $error("result changed while stalled");

  // Status set only with a zero denominator or idiv's fixed one.
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (result_den_o == 63'd0 || result_den_o == 63'd1))
    else $error("status set with nonzero denominator");

  // Order never takes the unused code.
  a_ord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (order_o != 2'd3))
    else $error("bad order code");

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .result_den_o, .order_o, .status_o
);
